// ===== design/positional_list_store_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional list store
// Shared helpers that wrap clocked implication checks on clk and rst.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_STORE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PLST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PLST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/plst_pkg.sv =====
// ----------------------------------------------------------------------------
// plst_pkg
// Widths, command and status codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 7;
  localparam int STATUS_W     = 2;
  localparam int SIZE_W       = 7;
  localparam int OP_W         = 2;

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READ_AT   = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  localparam logic [OP_W-1:0] OP_NONE   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic decide;
    logic rd_en;
    logic wr_shift;
    logic wr_value;
    logic cnt_inc;
    logic cnt_dec;
    logic finish;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ok;
    logic            more;
  } dp_stat_t;

endpackage

// ===== design/positional_list_store_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_store_top
// Bounded ordered list of signed words with insert, delete and read requests.
// ----------------------------------------------------------------------------
// Usage: drive cmd, value and position and raise start. A request is taken
// at a rising edge where start is high and busy is low. Busy stays high
// while the request is worked and drops in the cycle the result appears.
// Each request gives one result: status, list_size and read_value are valid
// for exactly one cycle while done is high. The receiver cannot stall, so
// the result must be captured in that cycle.
// Entries live in a single-port memory with a registered read, and every
// entry that moves costs one read, one write and one loop check. At most
// CAPACITY - 1 entries move. A new request can be taken in the cycle the
// previous result is shown, but not while one is still being worked.
// Reset clears the fill count and the sequencer; the memory keeps whatever
// it held, which is never visible because only entries below the fill
// count are read.
// ----------------------------------------------------------------------------
module positional_list_store_top #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [plst_pkg::CMD_W-1:0]         cmd,
  input  logic signed [plst_pkg::DATA_W-1:0] value,
  input  logic [plst_pkg::POS_W-1:0]         position,
  output logic                               done,
  output logic [plst_pkg::STATUS_W-1:0]      status,
  output logic [plst_pkg::SIZE_W-1:0]        list_size,
  output logic signed [plst_pkg::DATA_W-1:0] read_value
);
  import plst_pkg::*;

  // Command bundle from the sequencer and decode status back to it.
  ctl_t     ctl;
  dp_stat_t st;

  // The sequencer owns the handshake and steps the datapath one move at a time.
  plst_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .st    (st),
    .ctl   (ctl)
  );

  // The datapath holds the entries, the fill count and the result registers.
  plst_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .st         (st),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .list_size  (list_size),
    .read_value (read_value)
  );

endmodule

// ===== design/plst_ctrl.sv =====
// ----------------------------------------------------------------------------
// plst_ctrl
// Sequencer that walks one request through decode, entry moves and result.
// ----------------------------------------------------------------------------
module plst_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  plst_pkg::dp_stat_t st,
  output plst_pkg::ctl_t     ctl
);
  import plst_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_WR     = 3'd4;
  localparam logic [2:0] S_PUT    = 3'd5;
  localparam logic [2:0] S_DROP   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (!st.ok || st.op == OP_NONE) begin
          state_next = S_FINISH;
        end else if (st.op == OP_READ || st.more) begin
          state_next = S_RD;
        end else if (st.op == OP_INSERT) begin
          state_next = S_PUT;
        end else begin
          state_next = S_DROP;
        end
      end
      S_RD: begin
        ctl.rd_en  = 1'b1;
        state_next = (st.op == OP_READ) ? S_FINISH : S_WR;
      end
      S_WR: begin
        ctl.wr_shift = 1'b1;
        state_next   = S_CHECK;
      end
      S_PUT: begin
        ctl.wr_value = 1'b1;
        ctl.cnt_inc  = 1'b1;
        state_next   = S_FINISH;
      end
      S_DROP: begin
        ctl.cnt_dec = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        ctl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== design/plst_dp.sv =====
// ----------------------------------------------------------------------------
// plst_dp
// Entry memory, fill count, move index, request decode and result registers.
// ----------------------------------------------------------------------------
`include "positional_list_store_top_assert.svh"

module plst_dp #(
  parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  plst_pkg::ctl_t                     ctl,
  output plst_pkg::dp_stat_t                 st,
  input  logic [plst_pkg::CMD_W-1:0]         cmd,
  input  logic signed [plst_pkg::DATA_W-1:0] value,
  input  logic [plst_pkg::POS_W-1:0]         position,
  output logic                               done,
  output logic [plst_pkg::STATUS_W-1:0]      status,
  output logic [plst_pkg::SIZE_W-1:0]        list_size,
  output logic signed [plst_pkg::DATA_W-1:0] read_value
);
  import plst_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] mem_rdata;

  logic [CMD_W-1:0]    cmd_q;
  logic [DATA_W-1:0]   value_q;
  logic [POS_W-1:0]    pos_q;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    target_q;
  logic [OP_W-1:0]     op_q;
  logic [STATUS_W-1:0] stat_q;

  logic [OP_W-1:0]     op_d;
  logic [STATUS_W-1:0] stat_d;
  logic [CNT_W-1:0]    target_d;
  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    idx_step;
  logic [DATA_W-1:0]   wr_data;
  logic                full;

  assign pos_ext = CMP_W'(pos_q);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CNT_W'(CAPACITY));

  // Decode of the latched request against the current fill count.
  always_comb begin
    op_d     = OP_NONE;
    stat_d   = ST_OK;
    target_d = '0;
    unique case (cmd_q) inside
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        op_d = OP_INSERT;
        if (full) begin
          stat_d = ST_FULL;
        end else if (cmd_q == CMD_INS_BACK) begin
          target_d = count;
        end else if (cmd_q == CMD_INS_AT) begin
          if (pos_ext > cnt_ext) begin
            stat_d = ST_BADPOS;
          end else begin
            target_d = pos_ext[CNT_W-1:0];
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        op_d = OP_DELETE;
        if (count == '0) begin
          stat_d = ST_EMPTY;
        end else if (cmd_q == CMD_DEL_BACK) begin
          target_d = count - CNT_W'(1);
        end
      end
      CMD_DEL_AT, CMD_READ_AT: begin
        op_d = (cmd_q == CMD_DEL_AT) ? OP_DELETE : OP_READ;
        if (pos_ext >= cnt_ext) begin
          stat_d = ST_BADPOS;
        end else begin
          target_d = pos_ext[CNT_W-1:0];
        end
      end
      default: begin
        op_d = OP_NONE;
      end
    endcase
  end

  // Inserts walk down from the end, deletes walk up from the hole.
  always_comb begin
    case (op_q)
      OP_INSERT: begin
        rd_idx   = idx - CNT_W'(1);
        idx_step = idx - CNT_W'(1);
      end
      OP_DELETE: begin
        rd_idx   = idx + CNT_W'(1);
        idx_step = idx + CNT_W'(1);
      end
      default: begin
        rd_idx   = target_q;
        idx_step = idx;
      end
    endcase
  end

  assign wr_data = ctl.wr_value ? value_q : mem_rdata;

  assign st.op   = op_q;
  assign st.ok   = (stat_q == ST_OK);
  assign st.more = (op_q == OP_INSERT) ? (idx > target_q) : ((idx + CNT_W'(1)) < count);

  always_ff @(posedge clk) begin
    if (ctl.wr_shift || ctl.wr_value) begin
      mem[idx[ADDR_W-1:0]] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_rdata <= mem[rd_idx[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= cmd;
      value_q <= $unsigned(value);
      pos_q   <= position;
    end
    if (ctl.decide) begin
      op_q     <= op_d;
      stat_q   <= stat_d;
      target_q <= target_d;
      idx      <= (op_d == OP_INSERT) ? count : target_d;
    end else if (ctl.wr_shift) begin
      idx <= idx_step;
    end
    if (ctl.finish) begin
      status     <= stat_q;
      list_size  <= cnt_ext[SIZE_W-1:0];
      read_value <= (op_q == OP_READ && stat_q == ST_OK) ? $signed(mem_rdata) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctl.finish;
      if (ctl.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (ctl.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `PLST_ASSERT_IMP(a_cnt_bound, 1'b1, count <= CNT_W'(CAPACITY), "fill count above capacity")
  `PLST_ASSERT_IMP(a_cnt_excl, ctl.cnt_inc, !ctl.cnt_dec, "count raised and lowered at once")
  `PLST_ASSERT_IMP(a_put_target, ctl.wr_value, idx == target_q, "insert written off target")
  `PLST_ASSERT_NXT(a_done_pulse, ctl.finish, done && !ctl.finish, "result strobe missing")

endmodule

// ===== verif/positional_list_store_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_store_checker
// Watches the request and result ports of the list store, keeps a shadow copy
// of the list, and compares each result with the one the shadow list gives.
// ----------------------------------------------------------------------------
module positional_list_store_checker
  import plst_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [CMD_W-1:0]          cmd,
  input  logic signed [DATA_W-1:0]  value,
  input  logic [POS_W-1:0]          position,
  input  logic                      done,
  input  logic [STATUS_W-1:0]       status,
  input  logic [SIZE_W-1:0]         list_size,
  input  logic signed [DATA_W-1:0]  read_value,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SIZE_W-1:0]        list_size;
    logic signed [DATA_W-1:0] read_value;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_words [0:CAPACITY-1];
  int                       shadow_fill;
  list_result_t             awaited_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
    shadow_fill = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Applies one request to the shadow list and returns the result it gives.
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] c,
                                                      input logic signed [DATA_W-1:0] v,
                                                      input logic [POS_W-1:0] p);
    list_result_t r;
    int           at;
    int           removed;
    int           k;
    r.status     = ST_OK;
    r.read_value = '0;
    removed      = -1;
    case (c)
      CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
        if (shadow_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          if (c == CMD_INS_FRONT) at = 0;
          else if (c == CMD_INS_BACK) at = shadow_fill;
          else at = int'(p);
          if (at > shadow_fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (k = shadow_fill; k > at; k--) shadow_words[k] = shadow_words[k-1];
            shadow_words[at] = v;
            shadow_fill++;
          end
        end
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (shadow_fill == 0) r.status = ST_EMPTY;
        else removed = (c == CMD_DEL_FRONT) ? 0 : shadow_fill - 1;
      end
      CMD_DEL_AT: begin
        if (int'(p) >= shadow_fill) r.status = ST_BADPOS;
        else removed = int'(p);
      end
      CMD_READ_AT: begin
        if (int'(p) >= shadow_fill) r.status = ST_BADPOS;
        else r.read_value = shadow_words[p];
      end
      default: ;
    endcase
    if (removed >= 0) begin
      for (k = removed; k < shadow_fill - 1; k++) shadow_words[k] = shadow_words[k+1];
      shadow_fill--;
    end
    r.list_size = shadow_fill[SIZE_W-1:0];
    return r;
  endfunction

  // The result of one request may appear in the same cycle the next request
  // is taken, so the result is settled first.
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      shadow_fill = 0;
      awaited_results.delete();
    end else begin
      if (done) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no request outstanding", status, -1);
        end else begin
          want = awaited_results.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (list_size !== want.list_size)
            report_mismatch("list_size", list_size, want.list_size);
          if (read_value !== want.read_value)
            report_mismatch("read_value", read_value, want.read_value);
        end
      end
      if (start && !busy) awaited_results.push_back(apply_list_command(cmd, value, position));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== verif/positional_list_store_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_store_top_test
// Drives insert, delete and read requests into the list store, first a short
// directed set of edge cases, then random streams that grow, shrink and churn
// the list, with random idle bursts; a checker beside the block scores results.
// ----------------------------------------------------------------------------
module positional_list_store_top_test;
  import plst_pkg::*;

  // Code 7 has no meaning; the block must treat it as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  localparam int RANDOM_REQUESTS = 925;
  // The last stretch of random requests runs back to back with no idling.
  localparam int CALM_TAIL       = 150;
  // The slowest request moves CAPACITY - 1 entries, each with a read, a write and a check.
  localparam int DRAIN_CYCLES    = 3 * CAPACITY_DEF + 20;

  typedef enum int {MODE_GROW, MODE_SHRINK, MODE_CHURN} list_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;
  logic                     done;
  logic [STATUS_W-1:0]      status;
  logic [SIZE_W-1:0]        list_size;
  logic signed [DATA_W-1:0] read_value;
  int                       fail_count;
  int                       outstanding;

  // Last size reported by the block. It steers positions toward the live
  // part of the list; being one request behind does no harm.
  logic [SIZE_W-1:0]        last_size;

  positional_list_store_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .value      (value),
    .position   (position),
    .done       (done),
    .status     (status),
    .list_size  (list_size),
    .read_value (read_value)
  );

  positional_list_store_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .value       (value),
    .position    (position),
    .done        (done),
    .status      (status),
    .list_size   (list_size),
    .read_value  (read_value),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) last_size <= '0;
    else if (done) last_size <= list_size;
  end

  // Presents one request at a falling edge, optionally after an idle burst,
  // and returns just after the rising edge at which the block takes it.
  // Start is left high so that back-to-back requests need no extra step.
  task automatic issue_request(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                               input logic [POS_W-1:0] p, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    cmd      <= c;
    value    <= v;
    position <= p;
    do @(posedge clk); while (busy);
  endtask

  // Picks a random request. The mode tilts the mix toward inserts or deletes
  // so that the list spends time both full and empty.
  task automatic random_request(input list_mode_t mode, input bit may_idle);
    int                       roll;
    int                       ins_weight;
    int                       del_weight;
    logic [CMD_W-1:0]         c;
    logic signed [DATA_W-1:0] v;
    logic [POS_W-1:0]         p;
    case (mode)
      MODE_GROW:   begin ins_weight = 70; del_weight = 15; end
      MODE_SHRINK: begin ins_weight = 15; del_weight = 70; end
      default:     begin ins_weight = 40; del_weight = 38; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < ins_weight) begin
      case ($urandom_range(0, 2))
        0:       c = CMD_INS_FRONT;
        1:       c = CMD_INS_BACK;
        default: c = CMD_INS_AT;
      endcase
    end else if (roll < ins_weight + del_weight) begin
      case ($urandom_range(0, 2))
        0:       c = CMD_DEL_FRONT;
        1:       c = CMD_DEL_BACK;
        default: c = CMD_DEL_AT;
      endcase
    end else if (roll < 98) begin
      c = CMD_READ_AT;
    end else begin
      c = CMD_UNUSED;
    end
    // Mostly positions in or just past the live range; now and then any
    // 7-bit value, so that every position bit toggles.
    if ($urandom_range(0, 9) == 0) p = POS_W'($urandom_range(0, 127));
    else p = POS_W'($urandom_range(0, last_size));
    case ($urandom_range(0, 15))
      0:       v = 32'sh8000_0000;
      1:       v = 32'sh7fff_ffff;
      2:       v = -32'sd1;
      3:       v = '0;
      default: v = $urandom;
    endcase
    issue_request(c, v, p, may_idle);
  endtask

  initial begin
    list_mode_t mode;
    int         mode_left;
    int         n;
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_INS_FRONT;
    value    <= '0;
    position <= '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part. Requests on an empty list: every delete and read is
    // refused, and an insert past the end is refused too.
    issue_request(CMD_DEL_FRONT, 0, 0, 1'b0);
    issue_request(CMD_DEL_BACK,  0, 0, 1'b0);
    issue_request(CMD_DEL_AT,    0, 0, 1'b0);
    issue_request(CMD_READ_AT,   0, 0, 1'b0);
    issue_request(CMD_INS_AT,    32'sh1234_5678, 1, 1'b0);
    // A single entry, read back and then deleted, which must empty the list.
    issue_request(CMD_INS_AT,    32'sh8000_0000, 0, 1'b0);
    issue_request(CMD_READ_AT,   0, 0, 1'b0);
    issue_request(CMD_DEL_AT,    0, 0, 1'b0);
    // Build a short list from all sides, including an insert at the
    // position equal to the size, which appends.
    issue_request(CMD_INS_FRONT, 32'sh7fff_ffff, 0, 1'b0);
    issue_request(CMD_INS_BACK,  -32'sd1, 0, 1'b0);
    issue_request(CMD_INS_AT,    32'sh5555_5555, 1, 1'b0);
    issue_request(CMD_INS_AT,    32'shaaaa_aaaa, 3, 1'b0);
    issue_request(CMD_INS_FRONT, 0, 0, 1'b0);
    issue_request(CMD_READ_AT,   0, 4, 1'b0);
    // Reads at the size and at the largest position are out of range.
    issue_request(CMD_READ_AT,   0, 5, 1'b0);
    issue_request(CMD_READ_AT,   0, 7'h7f, 1'b0);
    // The unused code with every input bit set must change nothing.
    issue_request(CMD_UNUSED,    -32'sd1, 7'h7f, 1'b0);
    // Take the list apart from the middle and both ends.
    issue_request(CMD_DEL_AT,    0, 2, 1'b0);
    issue_request(CMD_DEL_FRONT, 0, 0, 1'b0);
    issue_request(CMD_DEL_BACK,  0, 0, 1'b0);
    issue_request(CMD_READ_AT,   0, 0, 1'b0);
    issue_request(CMD_DEL_AT,    0, 1, 1'b0);
    issue_request(CMD_DEL_BACK,  0, 0, 1'b0);
    issue_request(CMD_DEL_AT,    0, 64, 1'b0);
    issue_request(CMD_INS_BACK,  32'sh0000_0001, 0, 1'b0);

    // Random part: the list is pushed toward full, toward empty, or churned
    // around its current size, switching mode every hundred or so requests.
    mode      = MODE_GROW;
    mode_left = $urandom_range(60, 140);
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (mode_left == 0) begin
        mode      = list_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(60, 140);
      end
      mode_left--;
      random_request(mode, n < RANDOM_REQUESTS - CALM_TAIL);
    end

    @(negedge clk);
    start <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The slowest legal run is about 950 requests, each moving at most
  // CAPACITY - 1 entries, plus idle bursts, well below this bound.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
